### sv/hsv_pkg.sv
// Shared types and widths for the HDR RGB to HSV converter.
// Used by hsv_div_step and hdr_rgb_to_hsv_unit; depends on nothing.
package hsv_pkg;

    // Input component width (signed) and clamped component width
    localparam int unsigned IN_W   = 18;
    localparam int unsigned COMP_W = 17;

    // Hue numerator and divisor hold up to six times the range
    localparam int unsigned HUE_W  = 20;

    // Output quotient widths
    localparam int unsigned HUEQ_W = 16;
    localparam int unsigned SATQ_W = 17;

    // Number of one-bit division steps
    localparam int unsigned DIV_STEPS = 16;

    // Hue sector, chosen by which component is the minimum
    typedef enum logic [1:0] {
        SECT_RED_MIN,
        SECT_GREEN_MIN,
        SECT_BLUE_MIN
    } sector_t;

    // Work carried by one item through the division stages
    typedef struct packed {
        logic [HUE_W-1:0]  hue_rem;
        logic [HUE_W-1:0]  hue_div;
        logic [HUEQ_W-1:0] hue_q;
        logic [COMP_W-1:0] sat_rem;
        logic [COMP_W-1:0] sat_div;
        logic [SATQ_W-1:0] sat_q;
        logic [COMP_W-1:0] value;
    } div_state_t;

endpackage

### sv/hsv_div_step.sv
// One registered restoring-division step for both hue and saturation lanes.
// Depends on hsv_pkg for div_state_t and widths.
module hsv_div_step
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               valid_in,
    input  hsv_pkg::div_state_t state_in,
    output logic               valid_out,
    output hsv_pkg::div_state_t state_out
);
    import hsv_pkg::*;

    logic [HUE_W:0]    hue_sh;
    logic              hue_ge;
    logic [HUE_W:0]    hue_diff;
    logic [COMP_W:0]   sat_sh;
    logic              sat_ge;
    logic [COMP_W:0]   sat_diff;
    div_state_t        state_next;
    div_state_t        state_reg;
    logic              valid_reg;

    // Shift the partial remainder, subtract the divisor when it fits
    always_comb
    begin
        hue_sh   = {state_in.hue_rem, 1'b0};
        hue_ge   = hue_sh >= {1'b0, state_in.hue_div};
        hue_diff = hue_sh - {1'b0, state_in.hue_div};
        sat_sh   = {state_in.sat_rem, 1'b0};
        sat_ge   = sat_sh >= {1'b0, state_in.sat_div};
        sat_diff = sat_sh - {1'b0, state_in.sat_div};

        state_next         = state_in;
        state_next.hue_rem = hue_ge ? hue_diff[HUE_W-1:0] : hue_sh[HUE_W-1:0];
        state_next.hue_q   = {state_in.hue_q[HUEQ_W-2:0], hue_ge};
        state_next.sat_rem = sat_ge ? sat_diff[COMP_W-1:0] : sat_sh[COMP_W-1:0];
        state_next.sat_q   = {state_in.sat_q[SATQ_W-2:0], sat_ge};
    end

    // Advance the valid bit with reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    // Advance the payload; hold on stall
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            state_reg <= state_next;
        end
    end

    assign valid_out = valid_reg;
    assign state_out = state_reg;

endmodule

### sv/hdr_rgb_to_hsv_unit.sv
// Top level of the HDR RGB to HSV converter: clamp, min/max, hue setup, division.
// Depends on hsv_pkg and hsv_div_step.
//
//  channel | handshake           | payload
//  --------+---------------------+--------------------------------
//  input   | in_valid, in_stall  | red_in, green_in, blue_in
//  output  | out_valid, out_stall| hue_out, sat_out, value_out
//
// One item enters per clock unless the pipeline is stalled; four setup stages and
// sixteen one-bit division stages, each stage shared by the hue and
// saturation quotients. Reset clears all valid bits. A stall at the output
// while a result is shown freezes the whole pipeline and raises in_stall in
// the same cycle; nothing is lost or repeated.
module hdr_rgb_to_hsv_unit
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [hsv_pkg::IN_W-1:0]    red_in,
    input  logic [hsv_pkg::IN_W-1:0]    green_in,
    input  logic [hsv_pkg::IN_W-1:0]    blue_in,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [hsv_pkg::HUEQ_W-1:0]  hue_out,
    output logic [hsv_pkg::SATQ_W-1:0]  sat_out,
    output logic [hsv_pkg::COMP_W-1:0]  value_out
);
    import hsv_pkg::*;

    logic en;

    // Stage 1: clamped components, max and min
    logic [COMP_W-1:0] r_c, g_c, b_c;
    logic [COMP_W-1:0] mx_rg, mx_next, mn_rg, mn_next;
    logic [COMP_W-1:0] r1_reg, g1_reg, b1_reg, mx1_reg, mn1_reg;
    logic              v1_reg;

    // Stage 2: range, signed difference, sector
    logic [COMP_W-1:0] range2_next;
    logic signed [COMP_W:0] f2_next;
    sector_t           sect2_next;
    logic [COMP_W-1:0] range2_reg, mx2_reg;
    logic signed [COMP_W:0] f2_reg;
    sector_t           sect2_reg;
    logic              v2_reg;

    // Stage 3: hue numerator and divisor
    logic [HUE_W-1:0]  base3;
    logic signed [HUE_W:0] num3_wide;
    logic [HUE_W-1:0]  num3_next, d3_next;
    logic [HUE_W-1:0]  num3_reg, d3_reg;
    logic [COMP_W-1:0] range3_reg, mx3_reg;
    logic              v3_reg;

    // Stage 4: wrap, grey case, first saturation bit
    logic              grey4;
    logic              sat_top4;
    logic [HUE_W-1:0]  num4_wrap;
    div_state_t        s4_next;
    div_state_t        s4_reg;
    logic              v4_reg;

    // Division chain
    div_state_t        chain_state [0:DIV_STEPS];
    logic              chain_valid [0:DIV_STEPS];

    // Freeze everything while a shown result is held off
    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    // Clamp negatives, find max and min
    always_comb
    begin
        r_c     = red_in[IN_W-1]   ? '0 : red_in[COMP_W-1:0];
        g_c     = green_in[IN_W-1] ? '0 : green_in[COMP_W-1:0];
        b_c     = blue_in[IN_W-1]  ? '0 : blue_in[COMP_W-1:0];
        mx_rg   = (g_c > r_c) ? g_c : r_c;
        mx_next = (b_c > mx_rg) ? b_c : mx_rg;
        mn_rg   = (g_c < r_c) ? g_c : r_c;
        mn_next = (b_c < mn_rg) ? b_c : mn_rg;
    end

    // Pick the sector and the difference term
    always_comb
    begin
        range2_next = mx1_reg - mn1_reg;
        if (r1_reg == mn1_reg)
        begin
            sect2_next = SECT_RED_MIN;
            f2_next    = $signed({1'b0, g1_reg}) - $signed({1'b0, b1_reg});
        end
        else if (g1_reg == mn1_reg)
        begin
            sect2_next = SECT_GREEN_MIN;
            f2_next    = $signed({1'b0, b1_reg}) - $signed({1'b0, r1_reg});
        end
        else
        begin
            sect2_next = SECT_BLUE_MIN;
            f2_next    = $signed({1'b0, r1_reg}) - $signed({1'b0, g1_reg});
        end
    end

    // Form base times range minus difference, and six times range
    always_comb
    begin
        unique case (sect2_reg)
            SECT_RED_MIN:
            begin
                base3 = {2'b00, range2_reg, 1'b0} + {3'b000, range2_reg};
            end
            SECT_GREEN_MIN:
            begin
                base3 = {1'b0, range2_reg, 2'b00} + {3'b000, range2_reg};
            end
            default:
            begin
                base3 = {3'b000, range2_reg};
            end
        endcase
        num3_wide = $signed({1'b0, base3}) - (HUE_W+1)'(f2_reg);
        num3_next = num3_wide[HUE_W-1:0];
        d3_next   = {1'b0, range2_reg, 2'b00} + {2'b00, range2_reg, 1'b0};
    end

    // Wrap a full turn to zero; feed the divider a harmless divisor on grey
    always_comb
    begin
        grey4     = (range3_reg == '0);
        num4_wrap = (num3_reg == d3_reg) ? '0 : num3_reg;
        sat_top4  = !grey4 && (range3_reg == mx3_reg);

        s4_next.hue_rem = grey4 ? '0 : num4_wrap;
        s4_next.hue_div = grey4 ? HUE_W'(1) : d3_reg;
        s4_next.hue_q   = '0;
        s4_next.sat_rem = (grey4 || sat_top4) ? '0 : range3_reg;
        s4_next.sat_div = grey4 ? COMP_W'(1) : mx3_reg;
        s4_next.sat_q   = {{(SATQ_W-1){1'b0}}, sat_top4};
        s4_next.value   = mx3_reg;
    end

    // Advance valid bits of the setup stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // Advance setup payloads; hold on stall
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r1_reg     <= r_c;
            g1_reg     <= g_c;
            b1_reg     <= b_c;
            mx1_reg    <= mx_next;
            mn1_reg    <= mn_next;
            range2_reg <= range2_next;
            f2_reg     <= f2_next;
            sect2_reg  <= sect2_next;
            mx2_reg    <= mx1_reg;
            num3_reg   <= num3_next;
            d3_reg     <= d3_next;
            range3_reg <= range2_reg;
            mx3_reg    <= mx2_reg;
            s4_reg     <= s4_next;
        end
    end

    assign chain_state[0] = s4_reg;
    assign chain_valid[0] = v4_reg;

    // One quotient bit per stage for both lanes
    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_div
        hsv_div_step u_step
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid_in  (chain_valid[i]),
            .state_in  (chain_state[i]),
            .valid_out (chain_valid[i+1]),
            .state_out (chain_state[i+1])
        );
    end

    assign out_valid = chain_valid[DIV_STEPS];
    assign hue_out   = chain_state[DIV_STEPS].hue_q;
    assign sat_out   = chain_state[DIV_STEPS].sat_q;
    assign value_out = chain_state[DIV_STEPS].value;

endmodule
